[rtl/mm_pkg.sv]
// Shared types, constants and helpers for the matrix multiplier.
package mm_pkg;

  localparam int MAX_DIM_DEF    = 8;
  localparam int ELEM_WIDTH_DEF = 16;
  localparam int FRAC_BITS      = 8;
  localparam int ACTION_W       = 2;
  localparam int IDX_W          = 3;
  localparam int DIM_REG_W      = 4;
  localparam int CFG_IDX_W      = 2;
  localparam int QUEUE_DEPTH    = 2;
  localparam int CMD_ADDR_W     = 8;
  localparam int CMD_VAL_W      = 32;

  localparam logic [DIM_REG_W-1:0] DIM_RESET = 4'd8;

  typedef enum logic [ACTION_W-1:0] {
    ACT_LOAD_A  = 2'd0,
    ACT_LOAD_B  = 2'd1,
    ACT_COMPUTE = 2'd2
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROWS_A    = 2'd0,
    CFG_INNER_DIM = 2'd1,
    CFG_COLS_B    = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    action_t                 kind;
    logic [CMD_ADDR_W-1:0]   addr;
    logic [CMD_VAL_W-1:0]    value;
  } cmd_t;

  typedef struct packed {
    logic             first;
    logic             last_k;
    logic             last_res;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } tag_t;

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } back_state_t;

  // highest loop index for a dimension register, zero acting as one, values above max_dim acting as max_dim
  function automatic int last_index(input logic [DIM_REG_W-1:0] d, input int max_dim);
    int v;
    v = int'(d);
    if (v == 0) begin
      return 0;
    end
    if (v > max_dim) begin
      return max_dim - 1;
    end
    return v - 1;
  endfunction

endpackage

[rtl/mm_if.sv]
// Channel interfaces: command input, result output, configuration writes.
interface mm_cmd_if #(
  parameter int ELEM_WIDTH = mm_pkg::ELEM_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic [mm_pkg::ACTION_W-1:0]   action;
  logic [mm_pkg::IDX_W-1:0]      row;
  logic [mm_pkg::IDX_W-1:0]      col;
  logic signed [ELEM_WIDTH-1:0]  value;

  modport source (output valid, action, row, col, value, input ready);
  modport sink (input valid, action, row, col, value, output ready);
endinterface

interface mm_res_if #(
  parameter int ELEM_WIDTH = mm_pkg::ELEM_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic [mm_pkg::IDX_W-1:0]      out_row;
  logic [mm_pkg::IDX_W-1:0]      out_col;
  logic signed [ELEM_WIDTH-1:0]  out_value;
  logic                          saturated;
  logic                          last;

  modport source (output valid, out_row, out_col, out_value, saturated, last, input ready);
  modport sink (input valid, out_row, out_col, out_value, saturated, last, output ready);
endinterface

interface mm_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [mm_pkg::CFG_IDX_W-1:0]  index;
  logic [mm_pkg::DIM_REG_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/mm_front.sv]
// Front end: accepts command beats, drops out-of-range loads and unused action codes, forms queue entries.
module mm_front #(
  parameter int MAX_DIM    = mm_pkg::MAX_DIM_DEF,
  parameter int ELEM_WIDTH = mm_pkg::ELEM_WIDTH_DEF
) (
  mm_cmd_if.sink        cmd,
  output logic          push_valid,
  input  logic          push_ready,
  output mm_pkg::cmd_t  push_data
);
  import mm_pkg::*;

  logic keep;
  logic in_range;

  assign in_range = (int'(cmd.row) < MAX_DIM) && (int'(cmd.col) < MAX_DIM);

  always_comb begin
    case (action_t'(cmd.action))
      ACT_LOAD_A, ACT_LOAD_B: keep = in_range;
      ACT_COMPUTE:            keep = 1'b1;
      default:                keep = 1'b0;
    endcase
  end

  always_comb begin
    push_data.kind  = action_t'(cmd.action);
    push_data.addr  = CMD_ADDR_W'(int'(cmd.row) * MAX_DIM + int'(cmd.col));
    push_data.value = CMD_VAL_W'(unsigned'(cmd.value));
  end

  assign push_valid = cmd.valid && keep;
  assign cmd.ready  = !keep || push_ready;

endmodule

[rtl/mm_queue.sv]
// Small command queue between front end and back end.
module mm_queue #(
  parameter int DEPTH = mm_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  mm_pkg::cmd_t  push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output mm_pkg::cmd_t  pop_data
);
  import mm_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (int'(wr_ptr) == DEPTH - 1) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (int'(rd_ptr) == DEPTH - 1) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[rtl/mm_back.sv]
// Back end: element stores, dot-product sequencer, MAC pipeline, result register.
module mm_back #(
  parameter int MAX_DIM    = mm_pkg::MAX_DIM_DEF,
  parameter int ELEM_WIDTH = mm_pkg::ELEM_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  output logic          q_pop,
  input  mm_pkg::cmd_t  q_data,
  mm_cfg_if.sink        cfg,
  mm_res_if.source      result
);
  import mm_pkg::*;

  localparam int DIM_W    = $clog2(MAX_DIM);
  localparam int DEPTH    = MAX_DIM * MAX_DIM;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int PROD_W   = 2 * ELEM_WIDTH;
  localparam int ACC_FULL = PROD_W + $clog2(MAX_DIM) + 1;
  localparam int ACC_W    = (ACC_FULL > 64) ? 64 : ACC_FULL;
  localparam int Q_W      = ACC_W - FRAC_BITS;

  back_state_t state;
  back_state_t state_next;

  logic [DIM_REG_W-1:0] rows_a;
  logic [DIM_REG_W-1:0] inner_dim;
  logic [DIM_REG_W-1:0] cols_b;

  logic [DIM_W-1:0] nr_m1;
  logic [DIM_W-1:0] nk_m1;
  logic [DIM_W-1:0] nc_m1;
  logic [DIM_W-1:0] i;
  logic [DIM_W-1:0] j;
  logic [DIM_W-1:0] k;

  logic [ELEM_WIDTH-1:0] store_a [DEPTH];
  logic [ELEM_WIDTH-1:0] store_b [DEPTH];
  logic [ELEM_WIDTH-1:0] rd_a;
  logic [ELEM_WIDTH-1:0] rd_b;

  logic [ADDR_W-1:0]     waddr;
  logic [ELEM_WIDTH-1:0] wval;
  logic [ADDR_W-1:0]     raddr_a;
  logic [ADDR_W-1:0]     raddr_b;

  logic we_a;
  logic we_b;
  logic start;
  logic issue;
  logic adv;
  logic final_step;

  tag_t                     issue_tag;
  logic                     s1_valid;
  tag_t                     s1_tag;
  logic                     s2_valid;
  tag_t                     s2_tag;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  acc_sum;
  logic signed [Q_W-1:0]    q;
  logic [Q_W-ELEM_WIDTH:0]  q_top;
  logic                     fits;
  logic [ELEM_WIDTH-1:0]    sat_value;

  logic                  out_valid;
  logic [IDX_W-1:0]      out_row;
  logic [IDX_W-1:0]      out_col;
  logic [ELEM_WIDTH-1:0] out_value;
  logic                  out_sat;
  logic                  out_last;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_a    <= DIM_RESET;
      inner_dim <= DIM_RESET;
      cols_b    <= DIM_RESET;
    end else if (cfg.valid) begin
      case (cfg_idx_t'(cfg.index))
        CFG_ROWS_A:    rows_a    <= cfg.data;
        CFG_INNER_DIM: inner_dim <= cfg.data;
        CFG_COLS_B:    cols_b    <= cfg.data;
        default: ;
      endcase
    end
  end

  assign adv        = !out_valid || result.ready;
  assign final_step = (k == nk_m1) && (j == nc_m1) && (i == nr_m1);

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (q_valid && q_data.kind == ACT_COMPUTE) begin
          state_next = BK_RUN;
        end
      end
      BK_RUN: begin
        if (adv && final_step) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop = 1'b0;
    issue = 1'b0;
    case (state)
      BK_IDLE: q_pop = q_valid;
      BK_RUN:  issue = adv;
      default: ;
    endcase
  end

  assign we_a  = q_pop && (q_data.kind == ACT_LOAD_A);
  assign we_b  = q_pop && (q_data.kind == ACT_LOAD_B);
  assign start = q_pop && (q_data.kind == ACT_COMPUTE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      nr_m1 <= DIM_W'(last_index(rows_a, MAX_DIM));
      nk_m1 <= DIM_W'(last_index(inner_dim, MAX_DIM));
      nc_m1 <= DIM_W'(last_index(cols_b, MAX_DIM));
      i     <= '0;
      j     <= '0;
      k     <= '0;
    end else if (issue) begin
      if (k == nk_m1) begin
        k <= '0;
        if (j == nc_m1) begin
          j <= '0;
          i <= i + 1'b1;
        end else begin
          j <= j + 1'b1;
        end
      end else begin
        k <= k + 1'b1;
      end
    end
  end

  assign waddr   = q_data.addr[ADDR_W-1:0];
  assign wval    = q_data.value[ELEM_WIDTH-1:0];
  assign raddr_a = ADDR_W'(int'(i) * MAX_DIM + int'(k));
  assign raddr_b = ADDR_W'(int'(k) * MAX_DIM + int'(j));

  always_ff @(posedge clk) begin
    if (we_a) begin
      store_a[waddr] <= wval;
    end
    if (adv) begin
      rd_a <= store_a[raddr_a];
    end
  end

  always_ff @(posedge clk) begin
    if (we_b) begin
      store_b[waddr] <= wval;
    end
    if (adv) begin
      rd_b <= store_b[raddr_b];
    end
  end

  always_comb begin
    issue_tag.first    = (k == '0);
    issue_tag.last_k   = (k == nk_m1);
    issue_tag.last_res = final_step;
    issue_tag.row      = IDX_W'(i);
    issue_tag.col      = IDX_W'(j);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_valid  <= issue;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid && s2_tag.last_k;
    end
  end

  // truncate toward minus infinity, then clip to the element range
  always_comb begin
    acc_sum   = s2_tag.first ? ACC_W'(prod) : acc + ACC_W'(prod);
    q         = Q_W'(acc_sum >>> FRAC_BITS);
    q_top     = q[Q_W-1:ELEM_WIDTH-1];
    fits      = (&q_top) || !(|q_top);
    sat_value = q[Q_W-1] ? {1'b1, {(ELEM_WIDTH-1){1'b0}}}
                         : {1'b0, {(ELEM_WIDTH-1){1'b1}}};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_tag <= issue_tag;
      s2_tag <= s1_tag;
      prod   <= $signed(rd_a) * $signed(rd_b);
      if (s2_valid) begin
        acc <= acc_sum;
      end
      if (s2_valid && s2_tag.last_k) begin
        out_row   <= s2_tag.row;
        out_col   <= s2_tag.col;
        out_value <= fits ? q[ELEM_WIDTH-1:0] : sat_value;
        out_sat   <= !fits;
        out_last  <= s2_tag.last_res;
      end
    end
  end

  assign result.valid     = out_valid;
  assign result.out_row   = out_row;
  assign result.out_col   = out_col;
  assign result.out_value = out_value;
  assign result.saturated = out_sat;
  assign result.last      = out_last;

endmodule

[rtl/matrix_multiply_top.sv]
// Top level of the fixed-point matrix multiplier.
//
// Channels: cmd takes load-A, load-B and compute beats; cfg writes the
// rows_a, inner_dim and cols_b registers; result returns one beat per
// element of C = A * B in row-major order, last set on the final one.
// Load beats are taken one per cycle while the queue has room and written
// into the A or B store as they leave the command queue; out-of-range
// loads and unused action codes are accepted and dropped. A compute beat runs
// one MAC per cycle from the two store read ports while the result is not
// stalled, summing over the inner dimension for each result element.
// Commands behind a compute wait in a two-entry queue until its last MAC is
// issued.
// A stalled result holds the output register and freezes the MAC pipeline;
// commands keep entering the queue until it fills.
// Reset empties the queue and pipeline and sets all three dimensions to 8;
// the stores are not cleared and read undefined until loaded.
module matrix_multiply_top #(
  parameter int MAX_DIM    = mm_pkg::MAX_DIM_DEF,
  parameter int ELEM_WIDTH = mm_pkg::ELEM_WIDTH_DEF
) (
  input  logic     clk,
  input  logic     rst,
  mm_cmd_if.sink   cmd,
  mm_cfg_if.sink   cfg,
  mm_res_if.source result
);
  import mm_pkg::*;

  logic push_valid;
  logic push_ready;
  cmd_t push_data;
  logic pop_valid;
  logic pop_ready;
  cmd_t pop_data;

  mm_front #(
    .MAX_DIM    (MAX_DIM),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_front (
    .cmd        (cmd),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  mm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  mm_back #(
    .MAX_DIM    (MAX_DIM),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (pop_valid),
    .q_pop   (pop_ready),
    .q_data  (pop_data),
    .cfg     (cfg),
    .result  (result)
  );

endmodule

[rtl/mm_checker.sv]
// Port-level checks on the result channel, bound to the top level.
module mm_checker #(
  parameter int ELEM_WIDTH = mm_pkg::ELEM_WIDTH_DEF
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  res_valid,
  input logic                  res_ready,
  input logic [2:0]            res_row,
  input logic [2:0]            res_col,
  input logic [ELEM_WIDTH-1:0] res_value,
  input logic                  res_saturated,
  input logic                  res_last
);

  localparam logic [ELEM_WIDTH-1:0] VAL_MAX = {1'b0, {(ELEM_WIDTH-1){1'b1}}};
  localparam logic [ELEM_WIDTH-1:0] VAL_MIN = {1'b1, {(ELEM_WIDTH-1){1'b0}}};

  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result valid dropped while stalled");

  a_payload_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=>
      $stable({res_row, res_col, res_value, res_saturated, res_last}))
    else $error("result payload changed while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result beat right after reset");

  a_sat_clip: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_saturated |-> (res_value == VAL_MAX || res_value == VAL_MIN))
    else $error("saturated beat without a clipped value");

endmodule

bind matrix_multiply_top mm_checker #(
  .ELEM_WIDTH (ELEM_WIDTH)
) u_mm_checker (
  .clk           (clk),
  .rst           (rst),
  .res_valid     (result.valid),
  .res_ready     (result.ready),
  .res_row       (result.out_row),
  .res_col       (result.out_col),
  .res_value     (result.out_value),
  .res_saturated (result.saturated),
  .res_last      (result.last)
);
